/* sv/gregorian_date_day_of_year_converter_core_assert.svh */
// Assertion macros used by the checker file.
`ifndef GREGORIAN_DATE_DAY_OF_YEAR_CONVERTER_CORE_ASSERT_SVH
`define GREGORIAN_DATE_DAY_OF_YEAR_CONVERTER_CORE_ASSERT_SVH

// Same-cycle implication, masked while reset is held.
`define GDOY_ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("gdoy: same-cycle check failed");

// Next-cycle implication, masked while reset is held.
`define GDOY_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("gdoy: next-cycle check failed");

`endif

/* sv/gdoy_pkg.sv */
package gdoy_pkg;

    localparam int YEAR_BITS_DEF = 16;

    localparam int YEAR_W    = 16;
    localparam int MONTH_W   = 4;
    localparam int DAY_W     = 6;
    localparam int YDAY_W    = 9;
    localparam int DNUM_W    = 9;
    localparam int MOUT_W    = 4;
    localparam int DOUT_W    = 5;
    localparam int STATUS_W  = 3;

    // tdata layouts, rounded up to whole bytes
    localparam int IN_BITS     = YEAR_W + MONTH_W + DAY_W + YDAY_W;
    localparam int IN_DATA_W   = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS    = DNUM_W + MOUT_W + DOUT_W + STATUS_W;
    localparam int OUT_DATA_W  = ((OUT_BITS + 7) / 8) * 8;

    localparam int MONTH_LSB = YEAR_W;
    localparam int DAY_LSB   = MONTH_LSB + MONTH_W;
    localparam int YDAY_LSB  = DAY_LSB + DAY_W;

    localparam int MOUT_LSB   = DNUM_W;
    localparam int DOUT_LSB   = MOUT_LSB + MOUT_W;
    localparam int STATUS_LSB = DOUT_LSB + DOUT_W;

    localparam logic CMD_TO_YDAY = 1'b0;
    localparam logic CMD_TO_DATE = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 3'd0,
        ST_BAD_YEAR  = 3'd1,
        ST_BAD_MONTH = 3'd2,
        ST_BAD_DAY   = 3'd3,
        ST_BAD_YDAY  = 3'd4
    } t_status;

    // Inverse of an odd constant modulo 2^64 (Newton steps, 3 -> 96 bits).
    function automatic longint unsigned inv_odd(input longint unsigned d);
        longint unsigned x;
        x = d;
        for (int k = 0; k < 5; k++) begin
            x = x * (64'd2 - d * x);
        end
        return x;
    endfunction

    // Length of month m (1..12).
    function automatic logic [DOUT_W-1:0] month_len(input logic leap,
                                                   input logic [MONTH_W-1:0] m);
        logic [DOUT_W-1:0] len;
        case (m) inside
            4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
            4'd2:                    len = leap ? 5'd29 : 5'd28;
            default:                 len = 5'd31;
        endcase
        return len;
    endfunction

    // Days in the year before the first of month m (1..12).
    function automatic logic [DNUM_W-1:0] days_before(input logic leap,
                                                     input logic [MONTH_W-1:0] m);
        logic [DNUM_W-1:0] base;
        case (m)
            4'd2:    base = 9'd31;
            4'd3:    base = 9'd59;
            4'd4:    base = 9'd90;
            4'd5:    base = 9'd120;
            4'd6:    base = 9'd151;
            4'd7:    base = 9'd181;
            4'd8:    base = 9'd212;
            4'd9:    base = 9'd243;
            4'd10:   base = 9'd273;
            4'd11:   base = 9'd304;
            4'd12:   base = 9'd334;
            default: base = 9'd0;
        endcase
        return base + ((leap && m >= 4'd3) ? 9'd1 : 9'd0);
    endfunction

endpackage

/* sv/gregorian_date_day_of_year_converter_core.sv */
// Pipeline: an input transfer passes the input reg, then the result reg, before
//   its earliest result transfer.
// Throughput: one transfer per cycle; a stalled result lets one more transfer
//   into the input stage, then s_axis_tready drops until m_axis_tready returns.
// Reset: i_rst_n synchronous, active low; clears both stage valid flags,
//   payload registers are not reset.
module gregorian_date_day_of_year_converter_core #(
    parameter int YEAR_BITS = gdoy_pkg::YEAR_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    // input stream
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    // year[15:0], month[19:16], day[25:20], yearday[34:26], zero padded above
    input  logic [gdoy_pkg::IN_DATA_W-1:0]   s_axis_tdata,
    // command: 0 date -> day of year, 1 day of year -> date
    input  logic                             s_axis_tuser,
    // result stream
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    // day_number[8:0], month_out[12:9], day_out[17:13], status[20:18], zero padded
    output logic [gdoy_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);
    import gdoy_pkg::*;

    // Year arithmetic width: the year is masked to YEAR_BITS, never past the port.
    localparam int YW = (YEAR_BITS < YEAR_W) ? YEAR_BITS : YEAR_W;

    // Divisibility by 25 without a divider: for odd d, y % d == 0 exactly when
    // (y * d^-1 mod 2^YW) <= floor((2^YW - 1) / d).
    localparam logic [YW-1:0] INV25 = YW'(inv_odd(64'd25));
    localparam longint unsigned LIM25_FULL = ((64'd1 << YW) - 64'd1) / 64'd25;
    localparam logic [YW-1:0] LIM25 = YW'(LIM25_FULL);

    // ---------------- input stage ----------------
    logic              r_v1;
    logic              r_cmd;
    logic [YW-1:0]     r_year;
    logic [MONTH_W-1:0] r_month;
    logic [DAY_W-1:0]  r_day;
    logic [YDAY_W-1:0] r_yday;

    // ---------------- result stage ----------------
    logic              r_v2;
    logic [DNUM_W-1:0] r_dnum;
    logic [MOUT_W-1:0] r_mout;
    logic [DOUT_W-1:0] r_dout;
    t_status           r_status;

    logic              s2_ready;
    logic              s1_ready;

    // Each stage moves when it is empty or the stage after it moves.
    assign s2_ready      = !r_v2 || m_axis_tready;
    assign s1_ready      = !r_v1 || s2_ready;
    assign s_axis_tready = s1_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
        end else if (s1_ready) begin
            r_v1 <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s1_ready && s_axis_tvalid) begin
            r_cmd   <= s_axis_tuser;
            r_year  <= s_axis_tdata[YW-1:0];
            r_month <= s_axis_tdata[MONTH_LSB +: MONTH_W];
            r_day   <= s_axis_tdata[DAY_LSB +: DAY_W];
            r_yday  <= s_axis_tdata[YDAY_LSB +: YDAY_W];
        end
    end

    // ---------------- conversion logic ----------------
    logic [YW-1:0]     w_prod;
    logic              w_div25;
    logic              w_leap;
    logic [DOUT_W-1:0] w_mlen;
    logic [MOUT_W-1:0] w_mon;
    logic [DNUM_W-1:0] w_ylen;
    logic [DNUM_W-1:0] w_rem;
    t_status           n_status;
    logic [DNUM_W-1:0] n_dnum;
    logic [MOUT_W-1:0] n_mout;
    logic [DOUT_W-1:0] n_dout;

    assign w_prod  = YW'(r_year * INV25);
    assign w_div25 = (w_prod <= LIM25);
    // Leap: div by 4, except centuries unless div by 400 (= 16 * 25).
    assign w_leap  = (r_year[1:0] == 2'd0) && (!w_div25 || (r_year[3:0] == 4'd0));
    assign w_mlen  = month_len(w_leap, r_month);
    assign w_ylen  = w_leap ? 9'd366 : 9'd365;

    // Month of a day of year: last month that starts on or before it.
    always_comb begin
        w_mon = 4'd1;
        for (int i = 2; i <= 12; i++) begin
            if (r_yday > days_before(w_leap, MONTH_W'(i))) begin
                w_mon = MONTH_W'(i);
            end
        end
    end

    assign w_rem = r_yday - days_before(w_leap, w_mon);

    // Checks in order; any failure leaves the value fields at zero.
    always_comb begin
        n_status = ST_OK;
        n_dnum   = '0;
        n_mout   = '0;
        n_dout   = '0;
        if (r_year == '0) begin
            n_status = ST_BAD_YEAR;
        end else if (r_cmd == CMD_TO_YDAY) begin
            if (r_month == 4'd0 || r_month > 4'd12) begin
                n_status = ST_BAD_MONTH;
            end else if (r_day == '0 || r_day > DAY_W'(w_mlen)) begin
                n_status = ST_BAD_DAY;
            end else begin
                n_dnum = days_before(w_leap, r_month) + DNUM_W'(r_day);
            end
        end else begin
            if (r_yday == '0 || r_yday > w_ylen) begin
                n_status = ST_BAD_YDAY;
            end else begin
                n_mout = w_mon;
                n_dout = w_rem[DOUT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v2 <= 1'b0;
        end else if (s2_ready) begin
            r_v2 <= r_v1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s2_ready && r_v1) begin
            r_dnum   <= n_dnum;
            r_mout   <= n_mout;
            r_dout   <= n_dout;
            r_status <= n_status;
        end
    end

    assign m_axis_tvalid = r_v2;
    assign m_axis_tdata  = {(OUT_DATA_W - OUT_BITS)'(0), r_status, r_dout, r_mout, r_dnum};

endmodule

/* sv/gdoy_checker.sv */
`include "gregorian_date_day_of_year_converter_core_assert.svh"

module gdoy_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            m_axis_tvalid,
    input logic                            m_axis_tready,
    input logic [gdoy_pkg::OUT_DATA_W-1:0] m_axis_tdata
);
    import gdoy_pkg::*;

    logic [DNUM_W-1:0]   c_dnum;
    logic [MOUT_W-1:0]   c_mout;
    logic [DOUT_W-1:0]   c_dout;
    logic [STATUS_W-1:0] c_status;
    logic                c_ok;
    logic                c_stall;

    assign c_dnum   = m_axis_tdata[DNUM_W-1:0];
    assign c_mout   = m_axis_tdata[MOUT_LSB +: MOUT_W];
    assign c_dout   = m_axis_tdata[DOUT_LSB +: DOUT_W];
    assign c_status = m_axis_tdata[STATUS_LSB +: STATUS_W];
    assign c_ok     = m_axis_tvalid && (c_status == ST_OK);
    assign c_stall  = m_axis_tvalid && !m_axis_tready;

    // stalled result holds
    `GDOY_ASSERT_NEXT(a_stall_hold, i_clk, i_rst_n, c_stall,
        m_axis_tvalid && $stable(m_axis_tdata))

    // failed checks zero every value field
    `GDOY_ASSERT_IMPLY(a_fail_zero, i_clk, i_rst_n, m_axis_tvalid && !c_ok,
        c_dnum == '0 && c_mout == '0 && c_dout == '0)

    // a good result carries either a day number or a date, never both
    `GDOY_ASSERT_IMPLY(a_ok_one_form, i_clk, i_rst_n, c_ok,
        (c_dnum != '0) != (c_mout != '0 && c_dout != '0))

    // good results stay inside calendar ranges
    `GDOY_ASSERT_IMPLY(a_ok_range, i_clk, i_rst_n, c_ok,
        c_dnum <= 9'd366 && c_mout <= 4'd12 && c_dout <= 5'd31)

endmodule

bind gregorian_date_day_of_year_converter_core gdoy_checker u_gdoy_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

/* tb/gregorian_date_day_of_year_converter_core_tb.sv */
module gregorian_date_day_of_year_converter_core_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import gdoy_pkg::*;

    localparam int N_RANDOM     = 950;
    localparam int N_QUIET      = 150;   // tail of the random part with no idling
    localparam int HOLD_CYCLES  = 200;   // long receiver hold-off
    localparam int SETTLE_CYCLES = 8;    // pipeline is two deep; a few extra for margin
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct {
        logic              cmd;
        logic [YEAR_W-1:0] year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]  day;
        logic [YDAY_W-1:0] yday;
    } t_date_request;

    typedef struct {
        logic [DNUM_W-1:0] day_number;
        logic [MOUT_W-1:0] month_out;
        logic [DOUT_W-1:0] day_out;
        t_status           status;
    } t_date_answer;

    // Predicts the converter and holds answers in transfer order.
    class calendar_checker;
        t_date_answer expected_answers[$];
        int n_to_yday, n_to_date, n_checked, n_rejected, n_errors;

        function bit is_leap(logic [YEAR_W-1:0] y);
            return ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
        endfunction

        function int unsigned days_in_month(bit leap, int unsigned m);
            case (m)
                2:           return leap ? 29 : 28;
                4, 6, 9, 11: return 30;
                default:     return 31;
            endcase
        endfunction

        function t_date_answer convert_date(t_date_request rq);
            t_date_answer a;
            int unsigned left, m;
            bit leap;
            a.day_number = '0;
            a.month_out  = '0;
            a.day_out    = '0;
            a.status     = ST_OK;
            leap = is_leap(rq.year);
            // checks run in order: year, then month, then day / day of year
            if (rq.year == '0) begin
                a.status = ST_BAD_YEAR;
            end else if (rq.cmd == CMD_TO_YDAY) begin
                if (rq.month < 1 || rq.month > 12) begin
                    a.status = ST_BAD_MONTH;
                end else if (rq.day < 1 || rq.day > days_in_month(leap, rq.month)) begin
                    a.status = ST_BAD_DAY;
                end else begin
                    left = rq.day;
                    for (m = 1; m < rq.month; m++) left += days_in_month(leap, m);
                    a.day_number = left[DNUM_W-1:0];
                end
            end else begin
                if (rq.yday < 1 || rq.yday > (leap ? 366 : 365)) begin
                    a.status = ST_BAD_YDAY;
                end else begin
                    left = rq.yday;
                    m = 1;
                    while (m < 12 && left > days_in_month(leap, m)) begin
                        left -= days_in_month(leap, m);
                        m++;
                    end
                    a.month_out = m[MOUT_W-1:0];
                    a.day_out   = left[DOUT_W-1:0];
                end
            end
            return a;
        endfunction

        function void note_request(t_date_request rq);
            if (rq.cmd == CMD_TO_YDAY) n_to_yday++;
            else n_to_date++;
            expected_answers.push_back(convert_date(rq));
        endfunction

        function int pending();
            return expected_answers.size();
        endfunction

        function void check_result(logic [OUT_DATA_W-1:0] d);
            t_date_answer want, got;
            got.day_number = d[0 +: DNUM_W];
            got.month_out  = d[MOUT_LSB +: MOUT_W];
            got.day_out    = d[DOUT_LSB +: DOUT_W];
            got.status     = t_status'(d[STATUS_LSB +: STATUS_W]);
            if (expected_answers.size() == 0) begin
                $error("result transfer with no request outstanding: tdata=%h", d);
                n_errors++;
                return;
            end
            want = expected_answers.pop_front();
            n_checked++;
            if (want.status != ST_OK) n_rejected++;
            if (got.day_number !== want.day_number) begin
                $error("day_number: expected %0d, got %0d", want.day_number, got.day_number);
                n_errors++;
            end
            if (got.month_out !== want.month_out) begin
                $error("month_out: expected %0d, got %0d", want.month_out, got.month_out);
                n_errors++;
            end
            if (got.day_out !== want.day_out) begin
                $error("day_out: expected %0d, got %0d", want.day_out, got.day_out);
                n_errors++;
            end
            if (got.status !== want.status) begin
                $error("status: expected %0d, got %0d", want.status, got.status);
                n_errors++;
            end
        endfunction
    endclass

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  s_axis_tvalid;
    logic                  s_axis_tready;
    logic [IN_DATA_W-1:0]  s_axis_tdata;   // year, month, day, yearday from bit 0 up
    logic                  s_axis_tuser;   // command
    logic                  m_axis_tvalid;
    logic                  m_axis_tready;
    logic [OUT_DATA_W-1:0] m_axis_tdata;   // day_number, month_out, day_out, status from bit 0 up

    logic quiet;       // no idling on either side
    logic hold_go;     // asks the receiver for one long hold-off
    logic hold_done;

    calendar_checker sb = new();

    gregorian_date_day_of_year_converter_core DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Watchdog
    initial begin
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT,
                 sb.pending());
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Drive one request and hold it until the transfer happens.
    task automatic send_request(t_date_request rq);
        logic [IN_DATA_W-1:0] word;
        word = '0;
        word[0 +: YEAR_W]          = rq.year;
        word[MONTH_LSB +: MONTH_W] = rq.month;
        word[DAY_LSB +: DAY_W]     = rq.day;
        word[YDAY_LSB +: YDAY_W]   = rq.yday;
        @(negedge i_clk);
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= word;
        s_axis_tuser  <= rq.cmd;
        do @(posedge i_clk); while (s_axis_tready !== 1'b1);
        sb.note_request(rq);
    endtask

    task automatic send_fields(logic cmd, int unsigned year, int unsigned month,
                               int unsigned day, int unsigned yday);
        t_date_request rq;
        rq.cmd   = cmd;
        rq.year  = YEAR_W'(year);
        rq.month = MONTH_W'(month);
        rq.day   = DAY_W'(day);
        rq.yday  = YDAY_W'(yday);
        send_request(rq);
    endtask

    task automatic sender_pause(int n);
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        repeat (n - 1) @(negedge i_clk);
    endtask

    // Stop offering and wait until every result has been taken.
    task automatic wait_drained();
        @(negedge i_clk);
        s_axis_tvalid <= 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
    endtask

    // Biased toward leap-rule corners: multiples of 400, 100 and 4.
    function automatic logic [YEAR_W-1:0] pick_year();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 2)  return '0;
        if (r < 12) return YEAR_W'($urandom_range(1, 163) * 400);
        if (r < 22) return YEAR_W'($urandom_range(1, 655) * 100);
        if (r < 40) return YEAR_W'($urandom_range(1, 16383) * 4);
        if (r < 42) return '1;
        if (r < 70) return YEAR_W'($urandom_range(1583, 2400));
        return YEAR_W'($urandom_range(1, 65535));
    endfunction

    // Mostly well-formed requests near the month and year edges; one in ten is
    // raw noise across the full field ranges.
    task automatic random_request(output t_date_request rq);
        bit noise, leap;
        int unsigned len, r;
        noise    = ($urandom_range(0, 9) == 0);
        rq.cmd   = 1'($urandom_range(0, 1));
        rq.year  = pick_year();
        rq.month = MONTH_W'($urandom_range(0, 15));
        rq.day   = DAY_W'($urandom_range(0, 63));
        rq.yday  = YDAY_W'($urandom_range(0, 511));
        leap = sb.is_leap(rq.year);
        if (!noise) begin
            r = $urandom_range(0, 9);
            if (rq.cmd == CMD_TO_YDAY) begin
                rq.month = MONTH_W'($urandom_range(1, 12));
                len = sb.days_in_month(leap, rq.month);
                if (r == 0)      rq.day = DAY_W'(len + 1);
                else if (r == 1) rq.day = DAY_W'(len);
                else             rq.day = DAY_W'($urandom_range(1, len));
            end else begin
                len = leap ? 366 : 365;
                if (r == 0)      rq.yday = YDAY_W'(len + 1);
                else if (r == 1) rq.yday = YDAY_W'(len);
                else if (r == 2) rq.yday = YDAY_W'(1);
                else             rq.yday = YDAY_W'($urandom_range(1, len));
            end
        end
    endtask

    // Receiver: random stall bursts in changing modes, one long hold-off.
    initial begin
        int stall_left, mode, cyc;
        m_axis_tready = 1'b0;
        hold_done     = 1'b0;
        stall_left = 0;
        mode       = 0;
        cyc        = 0;
        forever begin
            @(negedge i_clk);
            if (cyc % 256 == 0) mode = $urandom_range(0, 2);
            cyc++;
            if (hold_go && !hold_done) begin
                stall_left = HOLD_CYCLES;
                hold_done  = 1'b1;
            end else if (stall_left == 0 && !quiet && mode != 0 &&
                         $urandom_range(0, (mode == 1) ? 15 : 3) == 0) begin
                stall_left = $urandom_range(1, 18);
            end
            if (stall_left > 0) begin
                m_axis_tready <= 1'b0;
                stall_left--;
            end else begin
                m_axis_tready <= 1'b1;
            end
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && m_axis_tvalid === 1'b1 && m_axis_tready === 1'b1)
                sb.check_result(m_axis_tdata);
        end
    end

    // Stimulus
    initial begin
        t_date_request rq;
        int send_mode;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        s_axis_tuser  = 1'b0;
        quiet         = 1'b0;
        hold_go       = 1'b0;
        send_mode     = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: check order, leap rule, month and year edges, ignored fields.
        send_fields(CMD_TO_YDAY, 0, 0, 0, 0);          // year zero beats bad month
        send_fields(CMD_TO_DATE, 0, 3, 3, 0);          // year zero beats bad yearday
        send_fields(CMD_TO_YDAY, 2024, 0, 0, 100);     // bad month beats bad day
        send_fields(CMD_TO_YDAY, 2023, 13, 5, 0);
        send_fields(CMD_TO_YDAY, 2023, 15, 63, 511);
        send_fields(CMD_TO_YDAY, 2023, 2, 29, 0);      // Feb 29 in a common year
        send_fields(CMD_TO_YDAY, 2024, 2, 29, 0);
        send_fields(CMD_TO_YDAY, 1900, 2, 29, 0);      // century, not leap
        send_fields(CMD_TO_YDAY, 2000, 2, 29, 0);      // divisible by 400
        send_fields(CMD_TO_YDAY, 2023, 1, 1, 0);
        send_fields(CMD_TO_YDAY, 2023, 12, 31, 0);
        send_fields(CMD_TO_YDAY, 2024, 12, 31, 0);
        send_fields(CMD_TO_YDAY, 2023, 4, 31, 0);      // 30-day month overrun
        send_fields(CMD_TO_YDAY, 2023, 5, 0, 0);       // day zero
        send_fields(CMD_TO_YDAY, 65535, 12, 31, 511);
        send_fields(CMD_TO_DATE, 2023, 0, 0, 0);       // yearday zero
        send_fields(CMD_TO_DATE, 2023, 0, 0, 366);     // past a common year
        send_fields(CMD_TO_DATE, 2024, 0, 0, 366);
        send_fields(CMD_TO_DATE, 2024, 0, 0, 60);      // Feb 29
        send_fields(CMD_TO_DATE, 2023, 0, 0, 60);      // Mar 1
        send_fields(CMD_TO_DATE, 2023, 15, 63, 1);
        send_fields(CMD_TO_DATE, 65535, 15, 63, 511);
        send_fields(CMD_TO_DATE, 1, 0, 0, 365);
        send_fields(CMD_TO_DATE, 2100, 0, 0, 366);
        wait_drained();

        for (int k = 0; k < N_RANDOM; k++) begin
            if (k % 100 == 0) send_mode = $urandom_range(0, 2);
            if (k == N_RANDOM - N_QUIET) quiet = 1'b1;
            if (k == 300) hold_go = 1'b1;     // sender keeps offering into the stall
            if (k == 600) wait_drained();
            random_request(rq);
            send_request(rq);
            if (!quiet && send_mode != 0 &&
                $urandom_range(0, (send_mode == 1) ? 9 : 2) == 0)
                sender_pause($urandom_range(1, 18));
        end

        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Converted %0d date-to-day-of-year and %0d day-of-year-to-date requests,",
                 sb.n_to_yday, sb.n_to_date);
        $display("%0d results compared, %0d of them rejected by range checks, %0d errors.",
                 sb.n_checked, sb.n_rejected, sb.n_errors);
        if (sb.n_errors == 0 && sb.pending() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
